FILE: rtl/tkd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared constants and types for the terminal key decoder with cursor.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS       = 12;
  localparam int KEY_BITS       = 9;

  localparam logic [DIM_BITS-1:0] ROWS_RESET = 12'd24;
  localparam logic [DIM_BITS-1:0] COLS_RESET = 12'd80;

  // register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // input command codes
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // bytes
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_O      = 8'h4f;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_4      = 8'h34;
  localparam logic [7:0] CH_5      = 8'h35;
  localparam logic [7:0] CH_6      = 8'h36;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;

  // key codes
  localparam logic [KEY_BITS-1:0] KEY_ESC    = 9'd27;
  localparam logic [KEY_BITS-1:0] KEY_LEFT   = 9'h068; // h
  localparam logic [KEY_BITS-1:0] KEY_DOWN   = 9'h06a; // j
  localparam logic [KEY_BITS-1:0] KEY_UP     = 9'h06b; // k
  localparam logic [KEY_BITS-1:0] KEY_RIGHT  = 9'h06c; // l
  localparam logic [KEY_BITS-1:0] KEY_QUIT   = 9'h071; // q
  localparam logic [KEY_BITS-1:0] KEY_HOME   = 9'd256;
  localparam logic [KEY_BITS-1:0] KEY_END    = 9'd257;
  localparam logic [KEY_BITS-1:0] KEY_DELETE = 9'd258;
  localparam logic [KEY_BITS-1:0] KEY_PGUP   = 9'd259;
  localparam logic [KEY_BITS-1:0] KEY_PGDN   = 9'd260;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] code;
  } key_t;

endpackage
`default_nettype wire

FILE: rtl/tkd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_decode
// Escape sequence parser: holds the sequence state and turns each word into
// at most one key.
// ----------------------------------------------------------------------------
module tkd_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,      // word in the input register is consumed
  input  wire logic          cmd,
  input  wire logic [7:0]    key_byte,
  output tkd_pkg::key_t      key
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_TILDE  = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic [tkd_pkg::KEY_BITS-1:0] second_key, tilde_key;
  logic is_digit;

  assign is_digit = (key_byte >= tkd_pkg::CH_0) && (key_byte <= tkd_pkg::CH_9);

  always_comb begin
    second_key = tkd_pkg::KEY_ESC;
    if (first_r == tkd_pkg::CH_LBRACK) begin
      case (key_byte)
        tkd_pkg::CH_A: second_key = tkd_pkg::KEY_UP;
        tkd_pkg::CH_B: second_key = tkd_pkg::KEY_DOWN;
        tkd_pkg::CH_C: second_key = tkd_pkg::KEY_RIGHT;
        tkd_pkg::CH_D: second_key = tkd_pkg::KEY_LEFT;
        tkd_pkg::CH_H: second_key = tkd_pkg::KEY_HOME;
        tkd_pkg::CH_F: second_key = tkd_pkg::KEY_END;
        default:       second_key = tkd_pkg::KEY_ESC;
      endcase
    end else if (first_r == tkd_pkg::CH_O) begin
      if (key_byte == tkd_pkg::CH_H) second_key = tkd_pkg::KEY_HOME;
      else if (key_byte == tkd_pkg::CH_F) second_key = tkd_pkg::KEY_END;
    end
  end

  always_comb begin
    tilde_key = tkd_pkg::KEY_ESC;
    if (key_byte == tkd_pkg::CH_TILDE) begin
      case (digit_r)
        tkd_pkg::CH_1, tkd_pkg::CH_7: tilde_key = tkd_pkg::KEY_HOME;
        tkd_pkg::CH_3:                tilde_key = tkd_pkg::KEY_DELETE;
        tkd_pkg::CH_4, tkd_pkg::CH_8: tilde_key = tkd_pkg::KEY_END;
        tkd_pkg::CH_5:                tilde_key = tkd_pkg::KEY_PGUP;
        tkd_pkg::CH_6:                tilde_key = tkd_pkg::KEY_PGDN;
        default:                      tilde_key = tkd_pkg::KEY_ESC;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    digit_nxt = digit_r;
    key.valid = 1'b0;
    key.code  = {1'b0, key_byte};
    if (cmd == tkd_pkg::CMD_TIMEOUT) begin
      // a pending sequence is abandoned as a bare escape
      key.valid = (phase_r != PH_IDLE);
      key.code  = tkd_pkg::KEY_ESC;
      phase_nxt = PH_IDLE;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (key_byte == tkd_pkg::CH_ESC) phase_nxt = PH_ESC;
          else key.valid = 1'b1;
        end
        PH_ESC: begin
          first_nxt = key_byte;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          if ((first_r == tkd_pkg::CH_LBRACK) && is_digit) begin
            digit_nxt = key_byte;
            phase_nxt = PH_TILDE;
          end else begin
            key.valid = 1'b1;
            key.code  = second_key;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          key.valid = 1'b1;
          key.code  = tilde_key;
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= 8'd0;
      digit_r <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tkd_cursor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_cursor
// Cursor position kept inside the screen, moved by decoded keys.
// ----------------------------------------------------------------------------
module tkd_cursor #(
  parameter int COORD_BITS = tkd_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire tkd_pkg::key_t               key,
  input  wire logic [tkd_pkg::DIM_BITS-1:0] screen_rows,
  input  wire logic [tkd_pkg::DIM_BITS-1:0] screen_cols,
  output logic      [COORD_BITS-1:0]       cur_x_nxt,
  output logic      [COORD_BITS-1:0]       cur_y_nxt
);

  // wide enough for the screen size and for 2**COORD_BITS
  localparam int LW = ((COORD_BITS > tkd_pkg::DIM_BITS) ? COORD_BITS : tkd_pkg::DIM_BITS) + 1;
  localparam logic [LW-1:0] CAP = LW'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [LW-1:0] rows_w, cols_w, rlim, clim, x_inc, y_inc, end_col;

  assign rows_w  = LW'(screen_rows);
  assign cols_w  = LW'(screen_cols);
  assign rlim    = (rows_w < CAP) ? rows_w : CAP;
  assign clim    = (cols_w < CAP) ? cols_w : CAP;
  assign x_inc   = LW'(cur_x_r) + LW'(1);
  assign y_inc   = LW'(cur_y_r) + LW'(1);
  assign end_col = (clim == '0) ? '0 : clim - LW'(1);

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    case (key.code)
      tkd_pkg::KEY_LEFT:  if (cur_x_r != '0) cur_x_nxt = cur_x_r - COORD_BITS'(1);
      tkd_pkg::KEY_UP:    if (cur_y_r != '0) cur_y_nxt = cur_y_r - COORD_BITS'(1);
      tkd_pkg::KEY_RIGHT: if (x_inc < clim) cur_x_nxt = x_inc[COORD_BITS-1:0];
      tkd_pkg::KEY_DOWN:  if (y_inc < rlim) cur_y_nxt = y_inc[COORD_BITS-1:0];
      tkd_pkg::KEY_HOME:  cur_x_nxt = '0;
      tkd_pkg::KEY_END:   cur_x_nxt = end_col[COORD_BITS-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else if (step && key.valid) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/terminal_key_decoder_cursor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor_core
// Keyboard byte decoder for VT100 escape sequences with a bounded cursor.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per keyboard byte, or a
// timeout word (in_cmd = 1) when a read returned nothing.
// Result channel (out_valid / out_stall): one word per decoded key with the
// key code, the cursor after the key and the quit flag for 'q'. Bytes that
// are part of an escape sequence, and timeouts while idle, give no word.
// A word is captured in the input register, then decoded and applied to the
// cursor, and its result is loaded into the output register whenever that
// register is empty or being drained.
// Throughput: one word per cycle while the result side does not stall; the
// only loop is the parser state and cursor update.
// A stall on the result side holds the output register and the input
// register; in_stall rises only while the input register is full and blocked.
// Reset (synchronous, active low) empties both registers, sets the parser
// idle, puts the cursor at 0,0 and loads 24 rows by 80 columns.
// Configuration writes go to screen_rows (index 0) and screen_cols (index 1).
// ----------------------------------------------------------------------------
module terminal_key_decoder_cursor_core #(
  parameter int COORD_BITS = tkd_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [7:0]                   in_key_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [tkd_pkg::KEY_BITS-1:0] out_key_code,
  output logic      [tkd_pkg::DIM_BITS-1:0] out_cursor_col,
  output logic      [tkd_pkg::DIM_BITS-1:0] out_cursor_row,
  output logic                              out_quit,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_index,
  input  wire logic [tkd_pkg::DIM_BITS-1:0] cfg_wdata
);

  localparam int EXT = (COORD_BITS > tkd_pkg::DIM_BITS) ? COORD_BITS : tkd_pkg::DIM_BITS;

  logic [tkd_pkg::DIM_BITS-1:0] rows_r, cols_r;
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;
  logic       advance, step;
  logic       out_valid_r;
  logic [tkd_pkg::KEY_BITS-1:0] out_key_r;
  logic [tkd_pkg::DIM_BITS-1:0] out_col_r, out_row_r;
  logic       out_quit_r;

  tkd_pkg::key_t key;
  logic [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt;
  logic [EXT-1:0] x_ext, y_ext;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= tkd_pkg::ROWS_RESET;
      cols_r <= tkd_pkg::COLS_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == tkd_pkg::CFG_ROWS) rows_r <= cfg_wdata;
      else cols_r <= cfg_wdata;
    end
  end

  // input register, loads whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_cmd_r  <= in_cmd;
      s1_byte_r <= in_key_byte;
    end
  end

  tkd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cmd      (s1_cmd_r),
    .key_byte (s1_byte_r),
    .key      (key)
  );

  tkd_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .key         (key),
    .screen_rows (rows_r),
    .screen_cols (cols_r),
    .cur_x_nxt   (cur_x_nxt),
    .cur_y_nxt   (cur_y_nxt)
  );

  assign x_ext = EXT'(cur_x_nxt);
  assign y_ext = EXT'(cur_y_nxt);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && key.valid) begin
      out_key_r  <= key.code;
      out_col_r  <= x_ext[tkd_pkg::DIM_BITS-1:0];
      out_row_r  <= y_ext[tkd_pkg::DIM_BITS-1:0];
      out_quit_r <= (key.code == tkd_pkg::KEY_QUIT);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = out_key_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_quit       = out_quit_r;

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked word");

  a_quit_matches_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quit == (out_key_code == tkd_pkg::KEY_QUIT)))
    else $error("quit flag does not match key code");

  a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=>
      (s1_valid_r && $stable(s1_cmd_r) && $stable(s1_byte_r)))
    else $error("input register changed while blocked");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !step)
    else $error("decoder advanced while result stalled");
`endif

endmodule
`default_nettype wire
